[rtl/btha_pkg.sv]
//==============================================================================
// btha_pkg
// Shared types and constants for the boundary-tag heap allocator.
//==============================================================================
package btha_pkg;

    // Command codes.
    localparam logic [1:0] CMD_INIT  = 2'd0;
    localparam logic [1:0] CMD_ALLOC = 2'd1;
    localparam logic [1:0] CMD_FREE  = 2'd2;

    // Status codes.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EXHAUSTED = 2'd1;
    localparam logic [1:0] ST_ZERO_SIZE = 2'd2;

    // Tag layout.
    localparam logic [31:0] SIZE_MASK = 32'hFFFF_FFF8;
    localparam logic [31:0] ALLOC_BIT = 32'h0000_0001;
    localparam logic [16:0] MIN_BLOCK = 17'd16;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] req_size;
        logic [15:0] block_addr;
    } cmd_t;

    typedef struct packed {
        logic [15:0] payload_addr;
        logic [1:0]  status;
    } result_t;

    // Memory request from the sequencer to the word store.
    typedef struct packed {
        logic        rd;
        logic        wr;
        logic [16:0] addr;
        logic [31:0] wdata;
    } mem_req_t;

endpackage

[rtl/boundary_tag_heap_allocator_core.sv]
//==============================================================================
// boundary_tag_heap_allocator_core
// First-fit heap allocator with header/footer boundary tags over a word RAM.
//==============================================================================
// Channel | Direction | Ports                  | Transfer
// cmd     | in        | start, busy, cmd       | start && !busy
// result  | out       | done, result           | done (one cycle, no stall)
//
// Each command runs through a sequencer around one memory port. The block
// walk reads one header tag per block visited. Init writes the padding,
// prologue and epilogue tags, then grows the heap. An alloc that finds no
// fit grows the heap with coalescing and then places the block; a free clears
// the tags and merges after the walk; then done is strobed. Reset clears the control
// state and pointers; the memory holds no reset value. busy stays high
// through the done cycle; results cannot be stalled.
//==============================================================================
module boundary_tag_heap_allocator_core #(
    parameter int HEAP_WORDS  = 16384,
    parameter int CHUNK_BYTES = 4096
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  btha_pkg::cmd_t     cmd,
    output logic               done,
    output btha_pkg::result_t  result
);
    import btha_pkg::*;

    localparam logic [16:0] MEM_BYTES  = (HEAP_WORDS * 4 > 65536) ? 17'd65536
                                         : 17'(HEAP_WORDS * 4);
    localparam logic [16:0] CHUNK      = 17'(CHUNK_BYTES);
    // Chunk growth in bytes: whole words, rounded up to an even word count.
    localparam int          CHUNK_WORDS = CHUNK_BYTES / 4;
    localparam logic [16:0] CHUNK_GROW = (CHUNK_WORDS % 2 == 1)
                                         ? 17'((CHUNK_WORDS + 1) * 4)
                                         : 17'(CHUNK_WORDS * 4);

    typedef enum logic [5:0] {
        S_IDLE, S_INIT0, S_INIT1, S_INIT2, S_INIT3,
        S_GROW, S_GROW1, S_GROW2, S_GROW3,
        S_M_PREVR, S_M_PREVW, S_M_PFR, S_M_PFW, S_M_NR, S_M_NW, S_M_SR, S_M_SW,
        S_M_NFR, S_M_NFW, S_M_APPLY, S_M_W2,
        S_WALK_R, S_WALK_W, S_WALK_D,
        S_PUT_R, S_PUT_W, S_PUT1, S_PUT2, S_PUT3,
        S_FREE_W1, S_FREE_W2, S_DONE
    } state_t;

    state_t      state_reg, state_next;
    logic [1:0]  op_reg, op_next;
    logic [16:0] brk_reg, brk_next;
    logic [16:0] pro_reg, pro_next;
    logic [16:0] req_reg, req_next;     // asize for alloc
    logic [16:0] tgt_reg, tgt_next;     // free target
    logic [16:0] bp_reg, bp_next;
    logic [16:0] sz_reg, sz_next;       // size of block at bp
    logic [16:0] prev_reg, prev_next;
    logic [16:0] nxt_reg, nxt_next;
    logic [16:0] acc_reg, acc_next;
    logic        pa_reg, pa_next, na_reg, na_next;
    logic [15:0] pay_reg, pay_next;
    logic [1:0]  st_reg, st_next;
    logic        done_reg, done_next;
    logic        merge_ret_reg, merge_ret_next;   // 1: merge called from alloc grow
    logic [16:0] gsize_reg, gsize_next;

    mem_req_t    mreq;
    logic [31:0] rdata;
    logic [16:0] rsz;
    logic [17:0] sum;

    btha_word_ram #(.HEAP_WORDS(HEAP_WORDS)) u_ram (
        .clk   (clk),
        .req   (mreq),
        .rdata (rdata)
    );

    // Size field of the word just read, clipped to the 17-bit address width.
    assign rsz  = (rdata[31:17] != 15'd0) ? 17'h1FFF8 : {rdata[16:3], 3'b000};
    assign sum  = 18'(bp_reg) + 18'(sz_reg);

    // Sequencer.
    always_comb
    begin
        logic [16:0] asz;
        logic [16:0] ext;
        state_next = state_reg; op_next = op_reg; brk_next = brk_reg; pro_next = pro_reg;
        req_next = req_reg; tgt_next = tgt_reg; bp_next = bp_reg; sz_next = sz_reg;
        prev_next = prev_reg; nxt_next = nxt_reg; acc_next = acc_reg;
        pa_next = pa_reg; na_next = na_reg; pay_next = pay_reg; st_next = st_reg;
        done_next = 1'b0; merge_ret_next = merge_ret_reg; gsize_next = gsize_reg;
        mreq = '0;
        asz = (cmd.req_size <= 16'd8) ? MIN_BLOCK
              : ((17'(cmd.req_size) + 17'd15) & 17'h1FFF8);
        ext = (req_reg > CHUNK) ? req_reg : CHUNK_GROW;
        case (state_reg)
            S_IDLE:
            begin
                if (start && !done_reg)
                begin
                    op_next = cmd.cmd; pay_next = '0; st_next = ST_OK;
                    tgt_next = 17'(cmd.block_addr); req_next = asz;
                    bp_next = pro_reg;
                    case (cmd.cmd)
                        CMD_INIT: state_next = S_INIT0;
                        CMD_ALLOC:
                        begin
                            if (cmd.req_size == 16'd0)
                            begin
                                st_next = ST_ZERO_SIZE; state_next = S_DONE;
                            end
                            else if (brk_reg == 17'd0)
                            begin
                                st_next = ST_EXHAUSTED; state_next = S_DONE;
                            end
                            else
                            begin
                                state_next = S_WALK_R;
                            end
                        end
                        CMD_FREE: state_next = (brk_reg == 17'd0) ? S_DONE : S_WALK_R;
                        default: state_next = S_DONE;
                    endcase
                end
            end
            // Padding, prologue header/footer, epilogue.
            S_INIT0:
            begin
                mreq = '{rd: 1'b0, wr: 1'b1, addr: 17'd0, wdata: 32'd0};
                state_next = S_INIT1;
            end
            S_INIT1:
            begin
                mreq = '{rd: 1'b0, wr: 1'b1, addr: 17'd4, wdata: 32'd9};
                state_next = S_INIT2;
            end
            S_INIT2:
            begin
                mreq = '{rd: 1'b0, wr: 1'b1, addr: 17'd8, wdata: 32'd9};
                state_next = S_INIT3;
            end
            S_INIT3:
            begin
                mreq = '{rd: 1'b0, wr: 1'b1, addr: 17'd12, wdata: ALLOC_BIT};
                brk_next = 17'd16; pro_next = 17'd8;
                gsize_next = CHUNK_GROW; merge_ret_next = 1'b0;
                state_next = S_GROW;
            end
            // Grow: check room, write header, footer, new epilogue.
            S_GROW:
            begin
                if (gsize_reg > MEM_BYTES - brk_reg)
                begin
                    st_next = ST_EXHAUSTED; state_next = S_DONE;
                end
                else
                begin
                    bp_next = brk_reg; sz_next = gsize_reg;
                    brk_next = brk_reg + gsize_reg;
                    state_next = S_GROW1;
                end
            end
            S_GROW1:
            begin
                mreq = '{rd: 1'b0, wr: 1'b1, addr: bp_reg - 17'd4, wdata: 32'(sz_reg)};
                state_next = S_GROW2;
            end
            S_GROW2:
            begin
                mreq = '{rd: 1'b0, wr: 1'b1, addr: 17'(sum - 18'd8), wdata: 32'(sz_reg)};
                state_next = S_GROW3;
            end
            S_GROW3:
            begin
                mreq = '{rd: 1'b0, wr: 1'b1, addr: 17'(sum - 18'd4), wdata: ALLOC_BIT};
                state_next = S_M_PREVR;
            end
            // Merge: bp_reg/sz_reg describe a free block with its tags written.
            S_M_PREVR:
            begin
                mreq = '{rd: 1'b1, wr: 1'b0, addr: bp_reg - 17'd8, wdata: 32'd0};
                state_next = S_M_PREVW;
            end
            S_M_PREVW:
            begin
                prev_next = bp_reg - {rdata[16:3], 3'b000};
                nxt_next = 17'(sum);
                state_next = S_M_PFR;
            end
            S_M_PFR:
            begin
                mreq = '{rd: 1'b1, wr: 1'b0, addr: prev_reg - 17'd4, wdata: 32'd0};
                state_next = S_M_PFW;
            end
            S_M_PFW:
            begin
                acc_next = rsz;   // prev size
                // prev footer address = prev + size - 8
                state_next = S_M_NR;
                prev_next = prev_reg;
                mreq = '0;
                sz_next = sz_reg;
                pa_next = 1'b0;
                nxt_next = nxt_reg;
                state_next = S_M_SR;
            end
            S_M_SR:
            begin
                mreq = '{rd: 1'b1, wr: 1'b0, addr: prev_reg + acc_reg - 17'd8, wdata: 32'd0};
                state_next = S_M_SW;
            end
            S_M_SW:
            begin
                pa_next = rdata[0];
                state_next = S_M_NR;
            end
            S_M_NR:
            begin
                mreq = '{rd: 1'b1, wr: 1'b0, addr: nxt_reg - 17'd4, wdata: 32'd0};
                state_next = S_M_NW;
            end
            S_M_NW:
            begin
                na_next = rdata[0];
                gsize_next = rsz;   // next size
                state_next = S_M_NFR;
            end
            S_M_NFR:
            begin
                // Next footer word (only needed when both neighbors free).
                mreq = '{rd: 1'b1, wr: 1'b0, addr: nxt_reg + gsize_reg - 17'd8, wdata: 32'd0};
                state_next = S_M_NFW;
            end
            S_M_NFW:
            begin
                if (pa_reg && na_reg)
                begin
                    state_next = S_M_W2;
                end
                else if (pa_reg)
                begin
                    sz_next = sz_reg + gsize_reg;
                    state_next = S_M_APPLY;
                end
                else if (na_reg)
                begin
                    sz_next = sz_reg + acc_reg; bp_next = prev_reg;
                    state_next = S_M_APPLY;
                end
                else
                begin
                    sz_next = sz_reg + acc_reg + rsz; bp_next = prev_reg;
                    state_next = S_M_APPLY;
                end
            end
            // Header and footer of the merged block.
            S_M_APPLY:
            begin
                mreq = '{rd: 1'b0, wr: 1'b1, addr: bp_reg - 17'd4, wdata: 32'(sz_reg)};
                acc_next = 17'd0;
                state_next = S_M_W2;
                pa_next = 1'b0;
                na_next = 1'b1;
            end
            S_M_W2:
            begin
                if (!(pa_reg && na_reg) || !na_reg)
                begin
                    mreq = '{rd: 1'b0, wr: 1'b1, addr: 17'(sum - 18'd8),
                             wdata: 32'(sz_reg)};
                end
                if (op_reg == CMD_ALLOC && merge_ret_reg)
                    state_next = S_PUT_R;
                else
                    state_next = S_DONE;
            end
            // Block list walk for first fit or free validation.
            S_WALK_R:
            begin
                if (bp_reg >= brk_reg)
                begin
                    state_next = S_WALK_D;
                end
                else
                begin
                    mreq = '{rd: 1'b1, wr: 1'b0, addr: bp_reg - 17'd4, wdata: 32'd0};
                    state_next = S_WALK_W;
                end
            end
            S_WALK_W:
            begin
                sz_next = rsz;
                if (rsz == 17'd0)
                begin
                    state_next = S_WALK_D;
                end
                else if (op_reg == CMD_FREE && bp_reg == tgt_reg)
                begin
                    if (bp_reg != pro_reg && rdata[0])
                        state_next = S_FREE_W1;
                    else
                        state_next = S_DONE;
                end
                else if (op_reg == CMD_ALLOC && !rdata[0] && req_reg <= rsz)
                begin
                    state_next = S_PUT_R;
                end
                else if (rsz > brk_reg - bp_reg)
                begin
                    state_next = S_WALK_D;
                end
                else
                begin
                    bp_next = bp_reg + rsz;
                    state_next = S_WALK_R;
                end
            end
            S_WALK_D:
            begin
                if (op_reg == CMD_ALLOC)
                begin
                    gsize_next = ext; merge_ret_next = 1'b1;
                    state_next = S_GROW;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            // Place: re-read size, then tag allocated part and remainder.
            S_PUT_R:
            begin
                mreq = '{rd: 1'b1, wr: 1'b0, addr: bp_reg - 17'd4, wdata: 32'd0};
                state_next = S_PUT_W;
            end
            S_PUT_W:
            begin
                acc_next = rsz;
                if (rsz - req_reg < MIN_BLOCK)
                    req_next = rsz;
                sz_next = (rsz - req_reg < MIN_BLOCK) ? rsz : req_reg;
                pay_next = bp_reg[15:0];
                state_next = S_PUT1;
            end
            S_PUT1:
            begin
                mreq = '{rd: 1'b0, wr: 1'b1, addr: bp_reg - 17'd4,
                         wdata: 32'(sz_reg) | ALLOC_BIT};
                state_next = S_PUT2;
            end
            S_PUT2:
            begin
                mreq = '{rd: 1'b0, wr: 1'b1, addr: 17'(sum - 18'd8),
                         wdata: 32'(sz_reg) | ALLOC_BIT};
                if (acc_reg == sz_reg)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    bp_next = 17'(sum); sz_next = acc_reg - sz_reg;
                    state_next = S_PUT3;
                end
            end
            S_PUT3:
            begin
                // The remainder footer goes out through the merge footer write.
                mreq = '{rd: 1'b0, wr: 1'b1, addr: bp_reg - 17'd4, wdata: 32'(sz_reg)};
                acc_next = sz_reg;
                merge_ret_next = 1'b0;
                pa_next = 1'b0; na_next = 1'b1;
                state_next = S_M_W2;
            end
            // Free: clear the flag in header and footer, then merge.
            S_FREE_W1:
            begin
                mreq = '{rd: 1'b0, wr: 1'b1, addr: bp_reg - 17'd4, wdata: 32'(sz_reg)};
                state_next = S_FREE_W2;
            end
            S_FREE_W2:
            begin
                mreq = '{rd: 1'b0, wr: 1'b1, addr: 17'(sum - 18'd8), wdata: 32'(sz_reg)};
                merge_ret_next = 1'b0;
                state_next = S_M_PREVR;
            end
            S_DONE:
            begin
                done_next = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE; brk_reg <= '0; pro_reg <= '0; done_reg <= 1'b0;
            op_reg <= '0; merge_ret_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next; brk_reg <= brk_next; pro_reg <= pro_next;
            done_reg <= done_next; op_reg <= op_next; merge_ret_reg <= merge_ret_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next; tgt_reg <= tgt_next; bp_reg <= bp_next; sz_reg <= sz_next;
        prev_reg <= prev_next; nxt_reg <= nxt_next; acc_reg <= acc_next;
        pa_reg <= pa_next; na_reg <= na_next; pay_reg <= pay_next; st_reg <= st_next;
        gsize_reg <= gsize_next;
    end

    assign busy   = (state_reg != S_IDLE) || done_reg;
    assign done   = done_reg;
    assign result = '{payload_addr: (op_reg == CMD_ALLOC && st_reg == ST_OK)
                                    ? pay_reg : 16'd0,
                      status: st_reg};

    // A result is strobed only in the cycle after the sequencer finishes.
    a_done_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == S_DONE)) else $error("done without finish");
    // The heap end never passes the memory.
    a_brk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        brk_reg <= MEM_BYTES) else $error("break past memory");
    // No command is accepted while a result is pending.
    a_no_accept_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy) else $error("accepted during result");
endmodule

[rtl/btha_word_ram.sv]
//==============================================================================
// btha_word_ram
// Single-port heap word memory with registered read data.
//==============================================================================
module btha_word_ram #(
    parameter int HEAP_WORDS = 16384
) (
    input  logic               clk,
    input  btha_pkg::mem_req_t req,
    output logic [31:0]        rdata
);
    import btha_pkg::*;

    localparam int AW = $clog2(HEAP_WORDS);

    logic [31:0] mem [HEAP_WORDS];
    logic [AW-1:0] idx;
    logic in_range;

    // Word index from the byte address; words past the end are not stored.
    assign idx      = AW'(req.addr >> 2);
    assign in_range = (32'(req.addr >> 2) < 32'(HEAP_WORDS));

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (req.wr && in_range)
        begin
            mem[idx] <= req.wdata;
        end
        if (req.rd)
        begin
            rdata <= in_range ? mem[idx] : 32'd0;
        end
    end
endmodule
